FILE: design/tlbe_pkg.sv
// Shared types and constants for the triangle Lagrange basis evaluator.
// No dependencies; used by every module of the block.
package tlbe_pkg;

    localparam int ORD_W           = 3;   // order and lattice index width
    localparam int BARY_W          = 18;  // Q2.16 coordinate
    localparam int FAC_W           = 40;  // Q.24 factor word
    localparam int OUT_W           = 32;  // Q8.24 result
    localparam int NUM_W           = 64;  // recurrence numerator
    localparam int DIV_W           = 48;  // divider dividend/quotient width
    localparam int DEF_ORDER_CAP   = 6;

    localparam logic [ORD_W-1:0]   DEF_ORDER = 3'd3;
    localparam logic [FAC_W-1:0]   FAC_LIM   = 40'h7F_FFFF_FFFF;
    localparam logic [FAC_W-1:0]   Q24_ONE   = 40'h00_0100_0000;

    typedef enum logic [3:0] {
        OPD_C1,
        OPD_D1,
        OPD_C2,
        OPD_D2,
        OPD_C3,
        OPD_D3,
        OPD_PA,
        OPD_PB,
        OPD_C23,
        OPD_T1,
        OPD_BASIS,
        OPD_TR,
        OPD_TS,
        OPD_CP,
        OPD_DP,
        OPD_F
    } opnd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F_INIT,
        S_F_INIT2,
        S_F_MLO,
        S_F_MHI,
        S_F_SUM,
        S_F_DIVST,
        S_F_DIV,
        S_V_RD,
        S_V_MLO,
        S_V_MHI,
        S_V_WB,
        S_V_EMIT
    } state_t;

    typedef struct packed {
        logic             cap_in;
        logic [ORD_W-1:0] n;
        logic             f_init;
        logic [1:0]       coord;
        logic [ORD_W-1:0] m;
        logic             mem_we;
        logic             wr_cd;
        logic             mul_lo;
        logic             mul_hi;
        opnd_t            mul_a;
        opnd_t            mul_b;
        logic             wb_en;
        opnd_t            wb_dst;
        logic             ld_en;
        opnd_t            ld_dst;
        logic [1:0]       rd_coord;
        logic             rd_cd;
        logic [ORD_W-1:0] rd_m;
        logic             sum;
        logic             add_cn;
        logic             div_start;
        logic             fac_store;
        logic             store_d;
        logic             emit;
        logic [ORD_W-1:0] idx_i;
        logic [ORD_W-1:0] idx_j;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: design/tlbe_div.sv
// Radix-16 restoring divider by a small order value (1..6).
// Depends on tlbe_pkg.
module tlbe_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tlbe_pkg::DIV_W-1:0]   dividend,
    input  logic [tlbe_pkg::ORD_W-1:0]   divisor,
    output logic                         done,
    output logic [tlbe_pkg::DIV_W-1:0]   quotient
);
    import tlbe_pkg::*;

    localparam int DIGITS = DIV_W / 4;
    localparam int CNT_W  = $clog2(DIGITS + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] sh_reg, sh_next;
    logic [ORD_W-1:0] rem_reg, rem_next;
    logic [3:0]       qdig;

    // one hex digit: four restoring steps on a remainder below the divisor
    always_comb
    begin
        logic [3:0] r;
        logic [3:0] nib;
        r   = {1'b0, rem_reg};
        nib = sh_reg[DIV_W-1 -: 4];
        qdig = '0;
        for (int b = 3; b >= 0; b--)
        begin
            r = {r[2:0], nib[b]};
            if (r >= {1'b0, divisor})
            begin
                r       = r - {1'b0, divisor};
                qdig[b] = 1'b1;
            end
        end
        rem_next = r[ORD_W-1:0];
        sh_next  = {sh_reg[DIV_W-5:0], qdig};
        cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_W'(DIGITS);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = (cnt_reg == '0);
    assign quotient = sh_reg;

endmodule

FILE: design/tlbe_dp.sv
// Datapath: factor memory, operand registers, shared two-pass multiplier,
// divider and output register. Depends on tlbe_pkg and tlbe_div.
module tlbe_dp #(
    parameter int ORDER_CAP = tlbe_pkg::DEF_ORDER_CAP
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlbe_pkg::dp_cmd_t                 cmd,
    output tlbe_pkg::dp_stat_t                stat,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_one,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_two,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_three,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tlbe_pkg::ORD_W-1:0]        index_i,
    output logic [tlbe_pkg::ORD_W-1:0]        index_j,
    output logic signed [tlbe_pkg::OUT_W-1:0] basis_value,
    output logic signed [tlbe_pkg::OUT_W-1:0] deriv_r,
    output logic signed [tlbe_pkg::OUT_W-1:0] deriv_s,
    output logic                              last_of_run
);
    import tlbe_pkg::*;

    localparam int MW    = $clog2(ORDER_CAP + 1);
    localparam int AW    = MW + 3;
    localparam int DEPTH = 2 ** AW;
    localparam int PW    = 78;

    // captured coordinates
    logic signed [BARY_W-1:0] l1_reg, l2_reg, l3_reg;
    // recurrence state
    logic signed [21:0]      t_reg;
    logic signed [FAC_W-1:0] cp_reg, dp_reg, cn_reg;
    logic signed [NUM_W-1:0] num_reg;
    // vertex operands and products
    logic signed [FAC_W-1:0] c1_reg, d1_reg, c2_reg, d2_reg, c3_reg, d3_reg;
    logic signed [FAC_W-1:0] pa_reg, pb_reg, c23_reg, t1_reg, basis_reg, tr_reg, ts_reg;
    // multiplier
    logic [PW-1:0]  prod_reg;
    logic [38:0]    amag_reg;
    logic [17:0]    bhi_reg;
    logic           neg_reg;
    // factor memory
    logic signed [FAC_W-1:0] mem [DEPTH];
    logic signed [FAC_W-1:0] fac_rd_reg;
    logic                    div_neg_reg;
    // output register
    logic                    out_valid_reg;
    logic [ORD_W-1:0]        idx_i_reg, idx_j_reg;
    logic signed [OUT_W-1:0] basis_out_reg, dr_out_reg, ds_out_reg;
    logic                    last_reg;

    logic signed [BARY_W-1:0] l_sel;
    logic signed [21:0]       t_val, f_val;
    logic [ORD_W-1:0]         mm1;
    logic [21:0]              f_off;
    logic signed [FAC_W-1:0]  a_val, b_val;
    logic [FAC_W-1:0]         a_mag, b_mag;
    logic [59:0]              lo_prod;
    logic [56:0]              hi_prod;
    logic [PW-1:0]            rnd;
    logic [53:0]              rq;
    logic [FAC_W-1:0]         q24_mag;
    logic signed [FAC_W-1:0]  q24_val;
    logic signed [NUM_W-1:0]  raw_val;
    logic signed [43:0]       cn_prod;
    logic signed [NUM_W-1:0]  cn_term;
    logic [NUM_W-1:0]         num_mag, num_rnd;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;
    logic [FAC_W-1:0]         dq_mag;
    logic signed [FAC_W-1:0]  dq_val;
    logic [AW-1:0]            waddr, raddr;
    logic signed [FAC_W-1:0]  wdata;
    logic signed [FAC_W:0]    sum_r, sum_s;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [FAC_W:0] v);
        logic signed [FAC_W:0] hi;
        logic signed [FAC_W:0] lo;
        hi = (FAC_W+1)'(32'sh7FFF_FFFF);
        lo = (FAC_W+1)'(32'sh8000_0000);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[OUT_W-1:0];
    endfunction

    function automatic logic signed [FAC_W-1:0] pick(
        input opnd_t sel,
        input logic signed [FAC_W-1:0] c1, d1, c2, d2, c3, d3, pa, pb, c23,
        input logic signed [FAC_W-1:0] cp, dp, f
    );
        case (sel)
            OPD_C1:  return c1;
            OPD_D1:  return d1;
            OPD_C2:  return c2;
            OPD_D2:  return d2;
            OPD_C3:  return c3;
            OPD_D3:  return d3;
            OPD_PA:  return pa;
            OPD_PB:  return pb;
            OPD_C23: return c23;
            OPD_CP:  return cp;
            OPD_DP:  return dp;
            OPD_F:   return f;
            default: return '0;
        endcase
    endfunction

    // coordinate for the current factor run, and n * L
    always_comb
    begin
        case (cmd.coord)
            2'd0:    l_sel = l1_reg;
            2'd1:    l_sel = l2_reg;
            default: l_sel = l3_reg;
        endcase
        t_val = 22'(l_sel * $signed({1'b0, cmd.n}));
        mm1   = cmd.m - 1'b1;
        f_off = {3'b000, mm1, 16'h0000};
        f_val = t_reg - $signed(f_off);
    end

    // multiplier: magnitude product split into a pass on the low 21 bits of b and a pass on its high bits
    always_comb
    begin
        a_val   = pick(cmd.mul_a, c1_reg, d1_reg, c2_reg, d2_reg, c3_reg, d3_reg,
                       pa_reg, pb_reg, c23_reg, cp_reg, dp_reg, FAC_W'(f_val));
        b_val   = pick(cmd.mul_b, c1_reg, d1_reg, c2_reg, d2_reg, c3_reg, d3_reg,
                       pa_reg, pb_reg, c23_reg, cp_reg, dp_reg, FAC_W'(f_val));
        a_mag   = a_val[FAC_W-1] ? FAC_W'(-a_val) : FAC_W'(a_val);
        b_mag   = b_val[FAC_W-1] ? FAC_W'(-b_val) : FAC_W'(b_val);
        lo_prod = a_mag[38:0] * b_mag[20:0];
        hi_prod = amag_reg * bhi_reg;
    end

    // Q.24 rescale with round half away, saturate, sign
    always_comb
    begin
        rnd     = prod_reg + PW'(24'h80_0000);
        rq      = rnd[PW-1:24];
        q24_mag = (rq > 54'(FAC_LIM)) ? FAC_LIM : rq[FAC_W-1:0];
        q24_val = neg_reg ? -$signed(q24_mag) : $signed(q24_mag);
        raw_val = neg_reg ? -$signed({1'b0, prod_reg[NUM_W-2:0]})
                          : $signed({1'b0, prod_reg[NUM_W-2:0]});
        cn_prod = cp_reg * $signed({1'b0, cmd.n});
        cn_term = NUM_W'(cn_prod) <<< 16;
    end

    // divider operand: (|num| + m * 2^15) >> 16, then divide by m
    always_comb
    begin
        num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        num_rnd = num_mag + (NUM_W'(cmd.m) << 15);
        dq_mag  = (div_q > DIV_W'(FAC_LIM)) ? FAC_LIM : div_q[FAC_W-1:0];
        dq_val  = div_neg_reg ? -$signed(dq_mag) : $signed(dq_mag);
    end

    tlbe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_rnd[NUM_W-1:16]),
        .divisor  (cmd.m),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        waddr = {cmd.wr_cd, cmd.coord, cmd.m[MW-1:0]};
        raddr = {cmd.rd_cd, cmd.rd_coord, cmd.rd_m[MW-1:0]};
        if (cmd.fac_store)
            wdata = dq_val;
        else if (cmd.wr_cd)
            wdata = '0;
        else
            wdata = $signed(Q24_ONE);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[waddr] <= wdata;
        fac_rd_reg <= mem[raddr];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            l1_reg <= bary_one;
            l2_reg <= bary_two;
            l3_reg <= bary_three;
        end
        if (cmd.f_init)
        begin
            t_reg  <= t_val;
            cp_reg <= $signed(Q24_ONE);
            dp_reg <= '0;
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= PW'(lo_prod);
            amag_reg <= a_mag[38:0];
            bhi_reg  <= b_mag[38:21];
            neg_reg  <= a_val[FAC_W-1] ^ b_val[FAC_W-1];
        end
        else if (cmd.mul_hi)
            prod_reg <= prod_reg + (PW'(hi_prod) << 21);
        if (cmd.sum)
            num_reg <= raw_val + (cmd.add_cn ? cn_term : '0);
        if (cmd.div_start)
            div_neg_reg <= num_reg[NUM_W-1];
        if (cmd.fac_store)
        begin
            if (!cmd.store_d)
                cn_reg <= dq_val;
            else
            begin
                dp_reg <= dq_val;
                cp_reg <= cn_reg;
            end
        end
        if (cmd.ld_en)
        begin
            case (cmd.ld_dst)
                OPD_C1:  c1_reg <= fac_rd_reg;
                OPD_D1:  d1_reg <= fac_rd_reg;
                OPD_C2:  c2_reg <= fac_rd_reg;
                OPD_D2:  d2_reg <= fac_rd_reg;
                OPD_C3:  c3_reg <= fac_rd_reg;
                OPD_D3:  d3_reg <= fac_rd_reg;
                default: ;
            endcase
        end
        if (cmd.wb_en)
        begin
            case (cmd.wb_dst)
                OPD_PA:    pa_reg    <= q24_val;
                OPD_PB:    pb_reg    <= q24_val;
                OPD_C23:   c23_reg   <= q24_val;
                OPD_T1:    t1_reg    <= -q24_val;
                OPD_BASIS: basis_reg <= q24_val;
                OPD_TR:    tr_reg    <= q24_val;
                OPD_TS:    ts_reg    <= q24_val;
                default:   ;
            endcase
        end
    end

    assign sum_r = (FAC_W+1)'(t1_reg) + (FAC_W+1)'(tr_reg);
    assign sum_s = (FAC_W+1)'(t1_reg) + (FAC_W+1)'(ts_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            idx_i_reg     <= cmd.idx_i;
            idx_j_reg     <= cmd.idx_j;
            basis_out_reg <= sat_out((FAC_W+1)'(basis_reg));
            dr_out_reg    <= sat_out(sum_r);
            ds_out_reg    <= sat_out(sum_s);
            last_reg      <= cmd.last;
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign index_i     = idx_i_reg;
    assign index_j     = idx_j_reg;
    assign basis_value = basis_out_reg;
    assign deriv_r     = dr_out_reg;
    assign deriv_s     = ds_out_reg;
    assign last_of_run = last_reg;

endmodule

FILE: design/tlbe_ctrl.sv
// Controller: order register, input handshake and the sequencer that walks
// the factor recurrences and the lattice. Depends on tlbe_pkg.
module tlbe_ctrl #(
    parameter int ORDER_CAP = tlbe_pkg::DEF_ORDER_CAP
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         interp_order_we,
    input  logic [tlbe_pkg::ORD_W-1:0]   interp_order,
    input  logic                         in_valid,
    output logic                         in_stall,
    output tlbe_pkg::dp_cmd_t            cmd,
    input  tlbe_pkg::dp_stat_t           stat
);
    import tlbe_pkg::*;

    localparam logic [2:0] LAST_OP = 3'd6;
    localparam logic [2:0] RD_LAST = 3'd6;

    state_t           state_reg, state_next;
    logic [ORD_W-1:0] order_reg;
    logic [ORD_W-1:0] n_reg, n_next;
    logic [1:0]       q_reg, q_next;
    logic [ORD_W-1:0] m_reg, m_next;
    logic             fd_reg, fd_next;
    logic [2:0]       rc_reg, rc_next;
    logic [2:0]       op_reg, op_next;
    logic [ORD_W-1:0] i_reg, i_next;
    logic [ORD_W-1:0] j_reg, j_next;
    logic [ORD_W-1:0] k_val;
    logic [2:0]       rc_m1;

    function automatic logic [ORD_W-1:0] clamp_order(input logic [ORD_W-1:0] v);
        if (v == '0)
            return ORD_W'(1);
        else if (v > ORD_W'(ORDER_CAP))
            return ORD_W'(ORDER_CAP);
        else
            return v;
    endfunction

    // product schedule per vertex; no product feeds the one right after it
    function automatic opnd_t op_src_a(input logic [2:0] op);
        case (op)
            3'd0:    return OPD_C1;
            3'd1:    return OPD_C2;
            3'd2:    return OPD_PA;
            3'd3:    return OPD_C1;
            3'd4:    return OPD_D1;
            3'd5:    return OPD_PA;
            default: return OPD_PB;
        endcase
    endfunction

    function automatic opnd_t op_src_b(input logic [2:0] op);
        case (op)
            3'd0:    return OPD_C2;
            3'd1:    return OPD_C3;
            3'd2:    return OPD_C3;
            3'd3:    return OPD_D2;
            3'd4:    return OPD_C23;
            3'd5:    return OPD_D3;
            default: return OPD_C3;
        endcase
    endfunction

    function automatic opnd_t op_dst(input logic [2:0] op);
        case (op)
            3'd0:    return OPD_PA;
            3'd1:    return OPD_C23;
            3'd2:    return OPD_BASIS;
            3'd3:    return OPD_PB;
            3'd4:    return OPD_T1;
            3'd5:    return OPD_TS;
            default: return OPD_TR;
        endcase
    endfunction

    function automatic opnd_t ld_dst(input logic [2:0] idx);
        case (idx)
            3'd0:    return OPD_C1;
            3'd1:    return OPD_D1;
            3'd2:    return OPD_C2;
            3'd3:    return OPD_D2;
            3'd4:    return OPD_C3;
            default: return OPD_D3;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= DEF_ORDER;
        else if (interp_order_we)
            order_reg <= interp_order;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= DEF_ORDER;
            q_reg     <= '0;
            m_reg     <= '0;
            fd_reg    <= 1'b0;
            rc_reg    <= '0;
            op_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            q_reg     <= q_next;
            m_reg     <= m_next;
            fd_reg    <= fd_next;
            rc_reg    <= rc_next;
            op_reg    <= op_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    assign k_val    = n_reg - i_reg - j_reg;
    assign rc_m1    = rc_reg - 1'b1;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        m_next     = m_reg;
        fd_next    = fd_reg;
        rc_next    = rc_reg;
        op_next    = op_reg;
        i_next     = i_reg;
        j_next     = j_reg;

        cmd          = '0;
        cmd.n        = n_reg;
        cmd.coord    = q_reg;
        cmd.m        = m_reg;
        cmd.mul_a    = OPD_CP;
        cmd.mul_b    = OPD_F;
        cmd.wb_dst   = OPD_PA;
        cmd.ld_dst   = OPD_C1;
        cmd.idx_i    = i_reg;
        cmd.idx_j    = j_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    n_next     = clamp_order(order_reg);
                    q_next     = '0;
                    fd_next    = 1'b0;
                    state_next = S_F_INIT;
                end
            end
            S_F_INIT:
            begin
                cmd.f_init = 1'b1;
                cmd.m      = '0;
                cmd.mem_we = 1'b1;
                cmd.wr_cd  = 1'b0;
                state_next = S_F_INIT2;
            end
            S_F_INIT2:
            begin
                cmd.m      = '0;
                cmd.mem_we = 1'b1;
                cmd.wr_cd  = 1'b1;
                m_next     = ORD_W'(1);
                state_next = S_F_MLO;
            end
            S_F_MLO:
            begin
                cmd.mul_lo = 1'b1;
                cmd.mul_a  = fd_reg ? OPD_DP : OPD_CP;
                cmd.mul_b  = OPD_F;
                state_next = S_F_MHI;
            end
            S_F_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_F_SUM;
            end
            S_F_SUM:
            begin
                cmd.sum    = 1'b1;
                cmd.add_cn = fd_reg;
                state_next = S_F_DIVST;
            end
            S_F_DIVST:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_F_DIV;
            end
            S_F_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.fac_store = 1'b1;
                    cmd.store_d   = fd_reg;
                    cmd.mem_we    = 1'b1;
                    cmd.wr_cd     = fd_reg;
                    if (!fd_reg)
                    begin
                        fd_next    = 1'b1;
                        state_next = S_F_MLO;
                    end
                    else
                    begin
                        fd_next = 1'b0;
                        if (m_reg == n_reg)
                        begin
                            if (q_reg == 2'd2)
                            begin
                                i_next     = '0;
                                j_next     = '0;
                                rc_next    = '0;
                                state_next = S_V_RD;
                            end
                            else
                            begin
                                q_next     = q_reg + 1'b1;
                                state_next = S_F_INIT;
                            end
                        end
                        else
                        begin
                            m_next     = m_reg + 1'b1;
                            state_next = S_F_MLO;
                        end
                    end
                end
            end
            S_V_RD:
            begin
                cmd.rd_cd    = rc_reg[0];
                cmd.rd_coord = rc_reg[2:1];
                case (rc_reg[2:1])
                    2'd0:    cmd.rd_m = i_reg;
                    2'd1:    cmd.rd_m = j_reg;
                    default: cmd.rd_m = k_val;
                endcase
                if (rc_reg != '0)
                begin
                    cmd.ld_en  = 1'b1;
                    cmd.ld_dst = ld_dst(rc_m1);
                end
                if (rc_reg == RD_LAST)
                begin
                    op_next    = '0;
                    state_next = S_V_MLO;
                end
                else
                    rc_next = rc_reg + 1'b1;
            end
            S_V_MLO:
            begin
                cmd.mul_lo = 1'b1;
                cmd.mul_a  = op_src_a(op_reg);
                cmd.mul_b  = op_src_b(op_reg);
                if (op_reg != '0)
                begin
                    cmd.wb_en  = 1'b1;
                    cmd.wb_dst = op_dst(op_reg - 1'b1);
                end
                state_next = S_V_MHI;
            end
            S_V_MHI:
            begin
                cmd.mul_hi = 1'b1;
                if (op_reg == LAST_OP)
                    state_next = S_V_WB;
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = S_V_MLO;
                end
            end
            S_V_WB:
            begin
                cmd.wb_en  = 1'b1;
                cmd.wb_dst = op_dst(op_reg);
                state_next = S_V_EMIT;
            end
            S_V_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (i_reg == n_reg);
                    rc_next  = '0;
                    if (i_reg == n_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        if (j_reg == n_reg - i_reg)
                        begin
                            i_next = i_reg + 1'b1;
                            j_next = '0;
                        end
                        else
                            j_next = j_reg + 1'b1;
                        state_next = S_V_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

FILE: design/triangle_lagrange_basis_eval.sv
// Top level of the triangle Lagrange basis evaluator (values and r/s slopes).
// Depends on tlbe_pkg, tlbe_ctrl, tlbe_dp (which holds tlbe_div).
//
//  channel   dir  handshake              payload
//  input     in   in_valid / in_stall    bary_one, bary_two, bary_three (Q2.16)
//  output    out  out_valid / out_stall  index_i, index_j, basis_value, deriv_r,
//                                        deriv_s (Q8.24), last_of_run
//  config    in   interp_order_we        interp_order (order n, 0 -> 1, >cap -> cap)
//
// The factor phase is bound by the radix-16 divider (two recurrence terms per
// step, each waiting on the divider); each vertex loads six operands from
// memory and takes 7 two-pass Q.24 products on the one shared multiplier.
// Reset clears the controller, the order register (to 3) and the output valid.
// in_stall is high from accept until the last vertex enters the output
// register; an output stall holds the sequencer only at vertex hand-off.
module triangle_lagrange_basis_eval #(
    parameter int ORDER_CAP = tlbe_pkg::DEF_ORDER_CAP
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               interp_order_we,
    input  logic [tlbe_pkg::ORD_W-1:0]         interp_order,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_one,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_two,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_three,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tlbe_pkg::ORD_W-1:0]         index_i,
    output logic [tlbe_pkg::ORD_W-1:0]         index_j,
    output logic signed [tlbe_pkg::OUT_W-1:0]  basis_value,
    output logic signed [tlbe_pkg::OUT_W-1:0]  deriv_r,
    output logic signed [tlbe_pkg::OUT_W-1:0]  deriv_s,
    output logic                               last_of_run
);
    import tlbe_pkg::*;

    dp_cmd_t  cmd;   // sequencer -> datapath
    dp_stat_t stat;  // divider done, output slot free

    // controller: order register, input transfer, recurrence and lattice walk
    tlbe_ctrl #(
        .ORDER_CAP (ORDER_CAP)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .interp_order_we (interp_order_we),
        .interp_order    (interp_order),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .stat            (stat)
    );

    // datapath: factor memory, multiplier, divider, output register
    tlbe_dp #(
        .ORDER_CAP (ORDER_CAP)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .bary_one    (bary_one),
        .bary_two    (bary_two),
        .bary_three  (bary_three),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .index_i     (index_i),
        .index_j     (index_j),
        .basis_value (basis_value),
        .deriv_r     (deriv_r),
        .deriv_s     (deriv_s),
        .last_of_run (last_of_run)
    );

endmodule

FILE: sim/tlbe_checker.sv
// Checker for triangle_lagrange_basis_eval: watches the order register and
// both channels, predicts every lattice vertex and compares. Needs tlbe_pkg.
module tlbe_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               interp_order_we,
    input  logic [tlbe_pkg::ORD_W-1:0]         interp_order,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_one,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_two,
    input  logic signed [tlbe_pkg::BARY_W-1:0] bary_three,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [tlbe_pkg::ORD_W-1:0]         index_i,
    input  logic [tlbe_pkg::ORD_W-1:0]         index_j,
    input  logic signed [tlbe_pkg::OUT_W-1:0]  basis_value,
    input  logic signed [tlbe_pkg::OUT_W-1:0]  deriv_r,
    input  logic signed [tlbe_pkg::OUT_W-1:0]  deriv_s,
    input  logic                               last_of_run,
    output int                                 errors,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlbe_pkg::*;

    localparam int TOP_ORDER = DEF_ORDER_CAP;
    localparam longint FLIM = (64'sd1 <<< 39) - 1;
    localparam longint ONE_Q24 = 64'sd1 <<< 24;
    localparam longint ONE_Q16 = 64'sd65536;

    typedef struct packed {
        logic [ORD_W-1:0] i;
        logic [ORD_W-1:0] j;
        logic [OUT_W-1:0] basis;
        logic [OUT_W-1:0] dr;
        logic [OUT_W-1:0] ds;
        logic             last;
    } vertex_t;

    vertex_t          vertex_q[$];
    logic [ORD_W-1:0] order_reg;

    assign pending = vertex_q.size();

    function automatic longint clamp_fac(input longint v);
        if (v > FLIM) return FLIM;
        if (v < -FLIM) return -FLIM;
        return v;
    endfunction

    // num / den, nearest, ties away from zero
    function automatic longint div_nearest(input longint num, input longint den);
        longint unsigned mg;
        longint unsigned q;
        mg = (num < 0) ? longint'(-num) : num;
        q = (mg + den / 2) / den;
        if (q > FLIM) q = FLIM;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // exact product rescaled by 2^-24, split so nothing overflows 64 bits
    function automatic longint mul_q24(input longint a, input longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned r;
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        r = ua * (ub >> 24) + ((ua * (ub & 64'hFF_FFFF) + (64'd1 << 23)) >> 24);
        if (r > FLIM) r = FLIM;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[OUT_W-1:0];
    endfunction

    // factor recurrence c and its slope d for one coordinate
    task automatic lagrange_factors(input longint lq, input int n,
                                    output longint c[0:TOP_ORDER],
                                    output longint d[0:TOP_ORDER]);
        longint f;
        longint den;
        for (int m = 0; m <= TOP_ORDER; m++) begin
            c[m] = 0;
            d[m] = 0;
        end
        c[0] = ONE_Q24;
        for (int m = 1; m <= n; m++) begin
            f = longint'(n) * lq - longint'(m - 1) * ONE_Q16;
            den = longint'(m) * ONE_Q16;
            c[m] = clamp_fac(div_nearest(c[m-1] * f, den));
            d[m] = clamp_fac(div_nearest(d[m-1] * f + c[m-1] * longint'(n) * ONE_Q16, den));
        end
    endtask

    task automatic predict_vertices(input longint l1, input longint l2, input longint l3);
        longint  c1[0:TOP_ORDER], c2[0:TOP_ORDER], c3[0:TOP_ORDER];
        longint  d1[0:TOP_ORDER], d2[0:TOP_ORDER], d3[0:TOP_ORDER];
        longint  c12, t1, tr, ts, bas;
        int      n, k;
        vertex_t v;
        n = order_reg;
        if (n < 1) n = 1;
        if (n > TOP_ORDER) n = TOP_ORDER;
        lagrange_factors(l1, n, c1, d1);
        lagrange_factors(l2, n, c2, d2);
        lagrange_factors(l3, n, c3, d3);
        for (int i = 0; i <= n; i++) begin
            for (int j = 0; j <= n - i; j++) begin
                k = n - i - j;
                c12 = mul_q24(c1[i], c2[j]);
                bas = mul_q24(c12, c3[k]);
                t1 = -mul_q24(d1[i], mul_q24(c2[j], c3[k]));
                tr = mul_q24(mul_q24(c1[i], d2[j]), c3[k]);
                ts = mul_q24(c12, d3[k]);
                v.i = ORD_W'(i);
                v.j = ORD_W'(j);
                v.basis = clamp_out(bas);
                v.dr = clamp_out(t1 + tr);
                v.ds = clamp_out(t1 + ts);
                v.last = (i == n);
                vertex_q.push_back(v);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n) begin
        vertex_t w;
        if (!rst_n) begin
            order_reg <= DEF_ORDER;
        end else begin
            if (interp_order_we)
                order_reg <= interp_order;
            if (in_valid && !in_stall)
                predict_vertices(bary_one, bary_two, bary_three);
            if (out_valid && !out_stall) begin
                if (vertex_q.size() == 0) begin
                    report_mismatch("vertex count", 1, 0);
                end else begin
                    w = vertex_q.pop_front();
                    if (index_i != w.i) report_mismatch("index_i", index_i, w.i);
                    if (index_j != w.j) report_mismatch("index_j", index_j, w.j);
                    if (basis_value != w.basis)
                        report_mismatch("basis_value", basis_value, $signed(w.basis));
                    if (deriv_r != w.dr) report_mismatch("deriv_r", deriv_r, $signed(w.dr));
                    if (deriv_s != w.ds) report_mismatch("deriv_s", deriv_s, $signed(w.ds));
                    if (last_of_run != w.last)
                        report_mismatch("last_of_run", last_of_run, w.last);
                end
            end
        end
    end

endmodule

FILE: sim/tb_triangle_lagrange_basis_eval.sv
// Testbench top for triangle_lagrange_basis_eval: stimulus, idling, verdict.
// Depends on tlbe_pkg, the block and tlbe_checker.
module tb_triangle_lagrange_basis_eval;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbe_pkg::*;

    // no-transfer cycles tolerated: worst vertex set plus the long hold-off, several times over
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 1500;
    localparam logic signed [BARY_W-1:0] B_MAX = 18'sh1FFFF;
    localparam logic signed [BARY_W-1:0] B_MIN = -18'sh20000;
    localparam logic signed [BARY_W-1:0] B_ONE = 18'sh10000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      interp_order_we;
    logic [ORD_W-1:0]          interp_order;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [BARY_W-1:0]  bary_one, bary_two, bary_three;
    logic                      out_valid;
    logic                      out_stall;
    logic [ORD_W-1:0]          index_i, index_j;
    logic signed [OUT_W-1:0]   basis_value, deriv_r, deriv_s;
    logic                      last_of_run;
    int                        errors, pending;

    int snd_idle_pct = 23;   // sender gap chance, percent
    int rcv_idle_pct = 62;   // receiver stall chance, percent
    int hold_reqs = 0;       // bumped by stimulus to ask for a long receiver hold-off
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    triangle_lagrange_basis_eval dut (
        .clk(clk), .rst_n(rst_n),
        .interp_order_we(interp_order_we), .interp_order(interp_order),
        .in_valid(in_valid), .in_stall(in_stall),
        .bary_one(bary_one), .bary_two(bary_two), .bary_three(bary_three),
        .out_valid(out_valid), .out_stall(out_stall),
        .index_i(index_i), .index_j(index_j),
        .basis_value(basis_value), .deriv_r(deriv_r), .deriv_s(deriv_s),
        .last_of_run(last_of_run)
    );

    tlbe_checker chk (
        .clk(clk), .rst_n(rst_n),
        .interp_order_we(interp_order_we), .interp_order(interp_order),
        .in_valid(in_valid), .in_stall(in_stall),
        .bary_one(bary_one), .bary_two(bary_two), .bary_three(bary_three),
        .out_valid(out_valid), .out_stall(out_stall),
        .index_i(index_i), .index_j(index_j),
        .basis_value(basis_value), .deriv_r(deriv_r), .deriv_s(deriv_s),
        .last_of_run(last_of_run),
        .errors(errors), .pending(pending)
    );

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("triangle_lagrange_basis_eval test failed");
            $finish;
        end
    end

    // One coordinate triple; returns at the edge where the transfer happens.
    task automatic send_coords(input logic signed [BARY_W-1:0] a,
                               input logic signed [BARY_W-1:0] b,
                               input logic signed [BARY_W-1:0] c);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        bary_one <= a;
        bary_two <= b;
        bary_three <= c;
        do @(posedge clk); while (in_stall);
    endtask

    // Mostly points on the plane L1+L2+L3 = 1 in one of three rotations, some raw 18-bit noise.
    task automatic send_random(input int count);
        int l1, l2, l3, pick;
        for (int q = 0; q < count; q++) begin
            if ($urandom_range(0, 9) < 7) begin
                l1 = $urandom_range(0, 65536);
                l2 = $urandom_range(0, 65536 - l1);
                l3 = 65536 - l1 - l2;
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    send_coords(BARY_W'(l1), BARY_W'(l2), BARY_W'(l3));
                else if (pick == 1)
                    send_coords(BARY_W'(l3), BARY_W'(l1), BARY_W'(l2));
                else
                    send_coords(BARY_W'(l2), BARY_W'(l3), BARY_W'(l1));
            end else begin
                send_coords(BARY_W'($urandom), BARY_W'($urandom), BARY_W'($urandom));
            end
        end
    endtask

    // Order change only when the block is drained and settled.
    task automatic write_order(input logic [ORD_W-1:0] n);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        interp_order_we <= 1'b1;
        interp_order <= n;
        @(posedge clk);
        interp_order_we <= 1'b0;
    endtask

    initial begin
        interp_order_we <= 1'b0;
        interp_order <= DEF_ORDER;
        in_valid <= 1'b0;
        bary_one <= '0;
        bary_two <= '0;
        bary_three <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed set at the reset order: vertices, centroid, field extremes
        send_coords(B_ONE, 0, 0);
        send_coords(0, B_ONE, 0);
        send_coords(0, 0, B_ONE);
        send_coords(21845, 21845, 21846);
        send_coords(0, 0, 0);
        send_coords(B_MAX, B_MAX, B_MAX);
        send_coords(B_MIN, B_MIN, B_MIN);
        send_coords(B_MAX, B_MIN, 0);
        send_coords(B_MIN, B_MAX, B_ONE);
        send_coords(-18'sd1, 18'sd1, 18'sd32768);
        send_coords(32768, 32768, 0);

        write_order(3'd1);
        send_random(15);
        // long receiver hold-off: block fills and stalls its input
        hold_reqs++;
        send_random(8);
        write_order(3'd6);
        send_coords(B_MAX, B_MAX, B_MAX);
        send_coords(B_MIN, B_MAX, B_MIN);
        send_random(6);

        snd_idle_pct = 62;
        rcv_idle_pct = 23;
        write_order(3'd0);
        send_coords(B_MIN, B_MAX, 0);
        send_random(18);
        write_order(3'd7);
        send_random(6);
        write_order(3'd2);
        send_random(22);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_order(3'd4);
        send_random(22);
        write_order(3'd5);
        send_random(12);
        write_order(3'd3);
        send_random(27);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("triangle_lagrange_basis_eval test passed");
        else
            $display("triangle_lagrange_basis_eval test failed");
        $finish;
    end

endmodule
